### rtl/core/urb_pkg.sv
// Shared types and constants for the UART ring buffer block.
`default_nettype none
package urb_pkg;

	typedef enum logic [2:0] {
		OP_RX_BYTE    = 3'd0,
		OP_READ       = 3'd1,
		OP_PUT        = 3'd2,
		OP_TX_DONE    = 3'd3,
		OP_FLUSH_RX   = 3'd4,
		OP_FLUSH_TX   = 3'd5,
		OP_CLEAR_FLAG = 3'd6,
		OP_NOP        = 3'd7
	} urb_op_t;

	localparam logic [7:0] TERM_AMP      = 8'h26;
	localparam logic [7:0] TERM_SPACE    = 8'h20;
	localparam int         SPACE_MIN_POS = 3;
	localparam int         LEVEL_W       = 7;

	// strobes from the controller, valid only in the accept cycle
	typedef struct packed {
		logic accept;
		logic rx_byte;
		logic rx_we;
		logic rx_pop;
		logic tx_direct;
		logic tx_we;
		logic tx_pop;
		logic rx_flush;
		logic tx_flush;
		logic flag_clr;
		logic drop;
	} urb_cmd_t;

	typedef struct packed {
		logic rx_room;
		logic rx_data;
		logic tx_room;
		logic tx_data;
	} urb_stat_t;

endpackage
`default_nettype wire

### rtl/core/urb_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface urb_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] data_byte;
	logic       tx_reg_empty;

	modport source (output valid, opcode, data_byte, tx_reg_empty, input ready);
	modport sink (input valid, opcode, data_byte, tx_reg_empty, output ready);
endinterface

interface urb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       read_valid;
	logic       send_valid;
	logic [7:0] send_byte;
	logic       message_complete;
	logic [6:0] rx_level;
	logic [6:0] tx_level;
	logic       dropped;

	modport source (output valid, read_data, read_valid, send_valid, send_byte,
		message_complete, rx_level, tx_level, dropped, input ready);
	modport sink (input valid, read_data, read_valid, send_valid, send_byte,
		message_complete, rx_level, tx_level, dropped, output ready);
endinterface
`default_nettype wire

### rtl/core/urb_ctrl.sv
// Controller: handshake sequencing and operation decode.
`default_nettype none
module urb_ctrl
	import urb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] opcode,
	input  wire logic       tx_reg_empty,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire urb_stat_t  stat,
	output urb_cmd_t        cmd
);

	typedef enum logic {ST_IDLE, ST_OUT} state_t;

	state_t state_q;
	logic   ready_q;
	logic   valid_q;
	logic   accept;

	assign accept    = in_valid & ready_q;
	assign in_ready  = ready_q;
	assign out_valid = valid_q;

	always_comb begin
		cmd        = '0;
		cmd.accept = accept;
		if (accept) begin
			case (urb_op_t'(opcode))
				OP_RX_BYTE: begin
					cmd.rx_byte = 1'b1;
					cmd.rx_we   = stat.rx_room;
					cmd.drop    = ~stat.rx_room;
				end
				OP_READ:  cmd.rx_pop = stat.rx_data;
				OP_PUT: begin
					if (tx_reg_empty && !stat.tx_data) begin
						cmd.tx_direct = 1'b1;
					end else begin
						cmd.tx_we = stat.tx_room;
						cmd.drop  = ~stat.tx_room;
					end
				end
				OP_TX_DONE:    cmd.tx_pop   = stat.tx_data;
				OP_FLUSH_RX:   cmd.rx_flush = 1'b1;
				OP_FLUSH_TX:   cmd.tx_flush = 1'b1;
				OP_CLEAR_FLAG: cmd.flag_clr = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					ready_q <= 1'b1;
					if (accept) begin
						state_q <= ST_OUT;
						ready_q <= 1'b0;
						valid_q <= 1'b1;
					end
				end
				ST_OUT: begin
					// hold the result until it is taken
					if (out_ready) begin
						state_q <= ST_IDLE;
						valid_q <= 1'b0;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b0;
					valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/urb_dp.sv
// Datapath: both rings, their pointers and fills, the message flag and result fields.
`default_nettype none
module urb_dp
	import urb_pkg::*;
#(
	parameter int RING_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire urb_cmd_t   cmd,
	input  wire logic [7:0] data_byte,
	output urb_stat_t       stat,
	output logic [7:0]      read_data,
	output logic            read_valid,
	output logic            send_valid,
	output logic [7:0]      send_byte,
	output logic            message_complete,
	output logic [6:0]      rx_level,
	output logic [6:0]      tx_level,
	output logic            dropped
);

	localparam int POS_W  = $clog2(RING_DEPTH);
	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam int EXT_W  = (FILL_W > LEVEL_W) ? FILL_W : LEVEL_W;
	localparam logic [POS_W-1:0]  LAST_POS = POS_W'(RING_DEPTH - 1);
	localparam logic [FILL_W-1:0] FULL     = FILL_W'(RING_DEPTH);

	logic [7:0] rx_mem [RING_DEPTH];
	logic [7:0] tx_mem [RING_DEPTH];

	logic [POS_W-1:0]  rx_rd_q, rx_wr_q, tx_rd_q, tx_wr_q;
	logic [FILL_W-1:0] rx_fill_q, tx_fill_q;
	logic              flag_q;
	logic [7:0]        rx_rdata_q, tx_rdata_q, byte_q;
	logic              rd_hit_q, snd_ring_q, snd_dir_q, drop_q;
	logic              term;
	logic [EXT_W-1:0]  rx_ext, tx_ext;

	function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
		return (p == LAST_POS) ? '0 : p + 1'b1;
	endfunction

	assign stat.rx_room = rx_fill_q < FULL;
	assign stat.rx_data = rx_fill_q != '0;
	assign stat.tx_room = tx_fill_q < FULL;
	assign stat.tx_data = tx_fill_q != '0;

	assign term = (data_byte == TERM_AMP) ||
		((data_byte == TERM_SPACE) && (rx_wr_q >= POS_W'(SPACE_MIN_POS)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_rd_q   <= '0;
			rx_wr_q   <= '0;
			rx_fill_q <= '0;
			tx_rd_q   <= '0;
			tx_wr_q   <= '0;
			tx_fill_q <= '0;
			flag_q    <= 1'b0;
		end else begin
			if (cmd.rx_byte && term) flag_q <= 1'b1;
			if (cmd.flag_clr) flag_q <= 1'b0;
			if (cmd.rx_we) begin
				rx_wr_q   <= next_pos(rx_wr_q);
				rx_fill_q <= rx_fill_q + 1'b1;
			end
			if (cmd.rx_pop) begin
				rx_rd_q   <= next_pos(rx_rd_q);
				rx_fill_q <= rx_fill_q - 1'b1;
			end
			if (cmd.rx_flush) begin
				rx_rd_q   <= '0;
				rx_wr_q   <= '0;
				rx_fill_q <= '0;
			end
			if (cmd.tx_we) begin
				tx_wr_q   <= next_pos(tx_wr_q);
				tx_fill_q <= tx_fill_q + 1'b1;
			end
			if (cmd.tx_pop) begin
				tx_rd_q   <= next_pos(tx_rd_q);
				tx_fill_q <= tx_fill_q - 1'b1;
			end
			if (cmd.tx_flush) begin
				tx_rd_q   <= '0;
				tx_wr_q   <= '0;
				tx_fill_q <= '0;
			end
		end
	end

	// ring storage: one write or one registered read per ring per item
	always_ff @(posedge clk) begin
		if (cmd.rx_we) rx_mem[rx_wr_q] <= data_byte;
		if (cmd.rx_pop) rx_rdata_q <= rx_mem[rx_rd_q];
		if (cmd.tx_we) tx_mem[tx_wr_q] <= data_byte;
		if (cmd.tx_pop) tx_rdata_q <= tx_mem[tx_rd_q];
	end

	// per-item result flags, captured when the item is accepted
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_hit_q   <= cmd.rx_pop;
			snd_ring_q <= cmd.tx_pop;
			snd_dir_q  <= cmd.tx_direct;
			drop_q     <= cmd.drop;
			byte_q     <= data_byte;
		end
	end

	assign rx_ext = EXT_W'(rx_fill_q);
	assign tx_ext = EXT_W'(tx_fill_q);

	assign read_data        = rd_hit_q ? rx_rdata_q : 8'h00;
	assign read_valid       = rd_hit_q;
	assign send_valid       = snd_ring_q | snd_dir_q;
	assign send_byte        = snd_ring_q ? tx_rdata_q : (snd_dir_q ? byte_q : 8'h00);
	assign message_complete = flag_q;
	assign rx_level         = rx_ext[LEVEL_W-1:0];
	assign tx_level         = tx_ext[LEVEL_W-1:0];
	assign dropped          = drop_q;

endmodule
`default_nettype wire

### rtl/core/uart_ring_buffers_with_message_detect_unit.sv
// Top level of the UART ring buffer block with message-complete detect.
// Each item carries one operation (receive byte, read, put, transmit done, flush
// either ring, clear flag, no-op) and yields exactly one result item. An item's
// result is presented in the cycle after it is accepted; the ring read is
// registered at the accepting edge, together with the result flags. The
// controller holds one item at a time and raises ready again at the edge where
// the result is taken, so the next item can be accepted in the cycle after; the
// block takes no new item until the result of the last one has been taken, so
// an output stall holds back the next item. Both rings hold RING_DEPTH bytes
// and need no clearing after reset.
`default_nettype none
module uart_ring_buffers_with_message_detect_unit
	import urb_pkg::*;
#(
	parameter int RING_DEPTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	urb_req_if.sink   req,
	urb_rsp_if.source rsp
);

	urb_cmd_t  cmd;
	urb_stat_t stat;

	urb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req.valid),
		.in_ready     (req.ready),
		.opcode       (req.opcode),
		.tx_reg_empty (req.tx_reg_empty),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	urb_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.data_byte        (req.data_byte),
		.stat             (stat),
		.read_data        (rsp.read_data),
		.read_valid       (rsp.read_valid),
		.send_valid       (rsp.send_valid),
		.send_byte        (rsp.send_byte),
		.message_complete (rsp.message_complete),
		.rx_level         (rsp.rx_level),
		.tx_level         (rsp.tx_level),
		.dropped          (rsp.dropped)
	);

endmodule
`default_nettype wire

### rtl/core/urb_chk.sv
// Port-level checks for the UART ring buffer block, bound to the top level.
`default_nettype none
module urb_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] read_data,
	input wire logic       read_valid,
	input wire logic       send_valid,
	input wire logic [7:0] send_byte,
	input wire logic       dropped
);

	// a stalled result holds its read and send fields
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) &&
		$stable(send_byte) && $stable(read_valid) && $stable(send_valid))
		else $error("stalled result changed");

	// one item at a time: no accept while a result is pending
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid)
		else $error("item accepted while result pending");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (read_valid || read_data == 8'h00) &&
		(send_valid || send_byte == 8'h00))
		else $error("unused result byte not zero");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(read_valid && send_valid) &&
		!(dropped && (read_valid || send_valid)))
		else $error("conflicting result flags");

endmodule

bind uart_ring_buffers_with_message_detect_unit urb_chk u_urb_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.read_data  (rsp.read_data),
	.read_valid (rsp.read_valid),
	.send_valid (rsp.send_valid),
	.send_byte  (rsp.send_byte),
	.dropped    (rsp.dropped)
);
`default_nettype wire
